// File: rtl/core/blt_pkg.sv
// blt_pkg: shared types, codes and character helpers for brace_list_tokenizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package blt_pkg;

  localparam int unsigned MAX_DEPTH = 255;

  typedef struct packed {
    logic        opcode;
    logic [15:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] char_out;
    logic [3:0]  value_type;
    logic [2:0]  error_code;
    logic [7:0]  nest_depth;
    logic        last;
  } out_item_t;

  localparam logic [2:0] EV_OPEN  = 3'd0;
  localparam logic [2:0] EV_CLOSE = 3'd1;
  localparam logic [2:0] EV_EMPTY = 3'd2;
  localparam logic [2:0] EV_CHAR  = 3'd3;
  localparam logic [2:0] EV_END   = 3'd4;
  localparam logic [2:0] EV_DONE  = 3'd5;
  localparam logic [2:0] EV_ERR   = 3'd6;

  localparam logic [2:0] ER_NONE    = 3'd0;
  localparam logic [2:0] ER_EXTRA   = 3'd1;
  localparam logic [2:0] ER_DELIM   = 3'd2;
  localparam logic [2:0] ER_UNFIN   = 3'd3;
  localparam logic [2:0] ER_MISSING = 3'd4;
  localparam logic [2:0] ER_DEEP    = 3'd5;

  localparam logic [3:0] VT_NONE    = 4'd0;
  localparam logic [3:0] VT_STRING  = 4'd1;
  localparam logic [3:0] VT_INT     = 4'd2;
  localparam logic [3:0] VT_EXP     = 4'd3;
  localparam logic [3:0] VT_GUID    = 4'd4;
  localparam logic [3:0] VT_B64     = 4'd5;
  localparam logic [3:0] VT_LINK    = 4'd6;
  localparam logic [3:0] VT_BARE64  = 4'd7;
  localparam logic [3:0] VT_DATA    = 4'd8;
  localparam logic [3:0] VT_UNKNOWN = 4'd9;

  // Classified character, front to back. Two result slots per item.
  typedef struct packed {
    logic        fin;       // end of text
    logic [15:0] ch;
  } cmd_t;

  function automatic logic is_dig(input logic [15:0] c);
    return c >= 16'd48 && c <= 16'd57;
  endfunction

  function automatic logic is_hex(input logic [15:0] c);
    return is_dig(c) || (c >= 16'd97 && c <= 16'd102) || (c >= 16'd65 && c <= 16'd70);
  endfunction

  function automatic logic is_b64(input logic [15:0] c);
    return is_dig(c) || (c >= 16'd97 && c <= 16'd122) || (c >= 16'd65 && c <= 16'd90) ||
           c == 16'd43 || c == 16'd61 || c == 16'd47 || c == 16'd13 || c == 16'd10;
  endfunction

  function automatic logic is_ws(input logic [15:0] c);
    return c == 16'd32 || c == 16'd9 || c == 16'd13 || c == 16'd10;
  endfunction

  function automatic logic [15:0] pfx_b64(input logic [2:0] i);
    logic [15:0] r;
    unique case (i)
      3'd0: r = 16'd35;
      3'd1: r = 16'd98;
      3'd2: r = 16'd97;
      3'd3: r = 16'd115;
      3'd4: r = 16'd101;
      3'd5: r = 16'd54;
      3'd6: r = 16'd52;
      default: r = 16'd58;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] pfx_data(input logic [2:0] i);
    logic [15:0] r;
    unique case (i)
      3'd0: r = 16'd35;
      3'd1: r = 16'd100;
      3'd2: r = 16'd97;
      3'd3: r = 16'd116;
      3'd4: r = 16'd97;
      3'd5: r = 16'd58;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/blt_front.sv
// blt_front: input stage; folds opcode and NUL into an end-of-text command
// and writes it to a two-entry queue. Depends on blt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module blt_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire blt_pkg::in_item_t in_data,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output blt_pkg::cmd_t         q_data
);
  blt_pkg::cmd_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r].fin <= in_data.opcode || (in_data.char_code == 16'd0);
      mem_r[wp_r].ch  <= in_data.char_code;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/blt_back.sv
// blt_back: parser state, value recognizers and result sequencing.
// Depends on blt_pkg. Each command makes up to two results, one per cycle while out_ready is high.
`timescale 1ns / 1ps
`default_nettype none
module blt_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire blt_pkg::cmd_t q_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output blt_pkg::out_item_t out_data
);
  typedef enum logic [5:0] {
    M_VALUE  = 6'b000001,
    M_DELIM  = 6'b000010,
    M_STRING = 6'b000100,
    M_QUOTE  = 6'b001000,
    M_BARE   = 6'b010000,
    M_FAILED = 6'b100000
  } mode_t;

  localparam logic [2:0] N_START = 3'd0, N_MINUS = 3'd1, N_INT = 3'd2, N_FRAC = 3'd3,
                         N_E = 3'd4, N_EMINUS = 3'd5, N_EXP = 3'd6, N_DEAD = 3'd7;
  localparam logic [1:0] L_START = 2'd0, L_DIGITS = 2'd1, L_HEX = 2'd2, L_DEAD = 2'd3;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  depth_r, depth_nxt;
  logic        nonempty_r, nonempty_nxt;
  logic [15:0] len_r, len_nxt;
  logic [2:0]  num_r, num_nxt;
  logic        guid_r, guid_nxt;
  logic [1:0]  lph_r, lph_nxt;
  logic [5:0]  lhex_r, lhex_nxt;
  logic        b64_r, b64_nxt, b64p_r, b64p_nxt, datp_r, datp_nxt;
  logic [2:0]  serr_r, serr_nxt;

  // output: slot 0 presented, slot 1 held
  blt_pkg::out_item_t o0_r, o0_nxt, o1_r, o1_nxt;
  logic [1:0]  ocnt_r, ocnt_nxt;

  blt_pkg::out_item_t r0, r1;
  logic [1:0]  k;
  logic        take;
  logic [15:0] c;
  logic [3:0]  vtype;

  function automatic blt_pkg::out_item_t mk(input logic [2:0] ev, input logic [15:0] ch,
      input logic [3:0] ty, input logic [2:0] er, input logic [7:0] d);
    blt_pkg::out_item_t o;
    o.event_res = ev; o.char_out = ch; o.value_type = ty;
    o.error_code = er; o.nest_depth = d; o.last = 1'b0;
    return o;
  endfunction

  assign c = q_data.ch;
  // only accept when the output slots are empty, or the last one drains this cycle
  assign q_ready   = (ocnt_r == 2'd0) || (ocnt_r == 2'd1 && out_ready);
  assign take      = q_valid && q_ready;
  assign out_valid = (ocnt_r != 2'd0);
  assign out_data  = o0_r;

  always_comb begin
    if (len_r == 16'd0) vtype = blt_pkg::VT_NONE;
    else if (num_r == N_INT) vtype = blt_pkg::VT_INT;
    else if (num_r == N_FRAC || num_r == N_EXP) vtype = blt_pkg::VT_EXP;
    else if (guid_r && len_r == 16'd36) vtype = blt_pkg::VT_GUID;
    else if (b64p_r && len_r >= 16'd8) vtype = blt_pkg::VT_B64;
    else if (lph_r == L_HEX && lhex_r == 6'd32) vtype = blt_pkg::VT_LINK;
    else if (b64_r) vtype = blt_pkg::VT_BARE64;
    else if (datp_r && len_r >= 16'd6) vtype = blt_pkg::VT_DATA;
    else vtype = blt_pkg::VT_UNKNOWN;
  end

  always_comb begin
    logic       fd, st, d, e, cl;
    mode_nxt = mode_r; depth_nxt = depth_r; nonempty_nxt = nonempty_r;
    len_nxt = len_r; num_nxt = num_r; guid_nxt = guid_r; lph_nxt = lph_r;
    lhex_nxt = lhex_r; b64_nxt = b64_r; b64p_nxt = b64p_r; datp_nxt = datp_r;
    serr_nxt = serr_r;
    r0 = '0; r1 = '0; k = 2'd0;
    fd = 1'b0; st = 1'b0; cl = 1'b0;
    d = blt_pkg::is_dig(c);
    e = (c == 16'd101 || c == 16'd69);
    if (q_data.fin) begin
      logic bad;
      bad = 1'b0;
      unique case (mode_r)
        M_BARE: begin
          r0 = mk(blt_pkg::EV_END, 16'd0, vtype, blt_pkg::ER_NONE, depth_r); k = 2'd1;
        end
        M_QUOTE: begin
          r0 = mk(blt_pkg::EV_END, 16'd0, blt_pkg::VT_STRING, blt_pkg::ER_NONE, depth_r);
          k = 2'd1;
        end
        M_DELIM: ;
        M_FAILED: begin
          r0 = mk(blt_pkg::EV_ERR, 16'd0, blt_pkg::VT_NONE, serr_r, depth_r);
          k = 2'd1; bad = 1'b1;
        end
        default: begin
          r0 = mk(blt_pkg::EV_ERR, 16'd0, blt_pkg::VT_NONE, blt_pkg::ER_UNFIN, depth_r);
          k = 2'd1; bad = 1'b1;
        end
      endcase
      if (!bad) begin
        blt_pkg::out_item_t t;
        t = (depth_r != 8'd0) ?
            mk(blt_pkg::EV_ERR, 16'd0, blt_pkg::VT_NONE, blt_pkg::ER_MISSING, depth_r) :
            mk(blt_pkg::EV_DONE, 16'd0, blt_pkg::VT_NONE, blt_pkg::ER_NONE, depth_r);
        if (k == 2'd0) r0 = t; else r1 = t;
        k = k + 2'd1;
      end
      mode_nxt = M_VALUE; depth_nxt = 8'd0; nonempty_nxt = 1'b0; serr_nxt = 3'd0;
      st = 1'b1;
    end else begin
      unique case (mode_r)
        M_VALUE: begin
          if (blt_pkg::is_ws(c)) begin
          end else if (c == 16'd34) begin
            mode_nxt = M_STRING;
          end else if (c == 16'd123) begin
            if (depth_r >= 8'(blt_pkg::MAX_DEPTH)) begin
              mode_nxt = M_FAILED; serr_nxt = blt_pkg::ER_DEEP;
              r0 = mk(blt_pkg::EV_ERR, 16'd0, blt_pkg::VT_NONE, blt_pkg::ER_DEEP, depth_r);
            end else begin
              depth_nxt = depth_r + 8'd1; nonempty_nxt = 1'b0;
              r0 = mk(blt_pkg::EV_OPEN, 16'd0, blt_pkg::VT_NONE, blt_pkg::ER_NONE, depth_nxt);
            end
            k = 2'd1;
          end else if (c == 16'd125) begin
            if (nonempty_r) begin
              r0 = mk(blt_pkg::EV_EMPTY, 16'd0, blt_pkg::VT_NONE, blt_pkg::ER_NONE, depth_r);
              k = 2'd1;
            end
            cl = 1'b1;
          end else if (c == 16'd44) begin
            nonempty_nxt = 1'b1;
            r0 = mk(blt_pkg::EV_EMPTY, 16'd0, blt_pkg::VT_NONE, blt_pkg::ER_NONE, depth_r);
            k = 2'd1;
          end else begin
            st = 1'b1; fd = 1'b1; nonempty_nxt = 1'b1; mode_nxt = M_BARE;
            r0 = mk(blt_pkg::EV_CHAR, c, blt_pkg::VT_NONE, blt_pkg::ER_NONE, depth_r);
            k = 2'd1;
          end
        end
        M_DELIM: begin
          if (blt_pkg::is_ws(c)) begin
          end else if (c == 16'd44) begin
            mode_nxt = M_VALUE;
          end else if (c == 16'd125) begin
            cl = 1'b1;
          end else begin
            mode_nxt = M_FAILED; serr_nxt = blt_pkg::ER_DELIM;
            r0 = mk(blt_pkg::EV_ERR, 16'd0, blt_pkg::VT_NONE, blt_pkg::ER_DELIM, depth_r);
            k = 2'd1;
          end
        end
        M_STRING: begin
          if (c == 16'd34) mode_nxt = M_QUOTE;
          else begin
            r0 = mk(blt_pkg::EV_CHAR, c, blt_pkg::VT_NONE, blt_pkg::ER_NONE, depth_r);
            k = 2'd1;
          end
        end
        M_QUOTE: begin
          if (c == 16'd34) begin
            mode_nxt = M_STRING;
            r0 = mk(blt_pkg::EV_CHAR, c, blt_pkg::VT_NONE, blt_pkg::ER_NONE, depth_r);
            k = 2'd1;
          end else begin
            nonempty_nxt = 1'b1;
            r0 = mk(blt_pkg::EV_END, 16'd0, blt_pkg::VT_STRING, blt_pkg::ER_NONE, depth_r);
            k = 2'd1;
            if (blt_pkg::is_ws(c)) mode_nxt = M_DELIM;
            else if (c == 16'd44) mode_nxt = M_VALUE;
            else if (c == 16'd125) cl = 1'b1;
            else begin
              mode_nxt = M_FAILED; serr_nxt = blt_pkg::ER_DELIM;
              r1 = mk(blt_pkg::EV_ERR, 16'd0, blt_pkg::VT_NONE, blt_pkg::ER_DELIM, depth_r);
              k = 2'd2;
            end
          end
        end
        M_BARE: begin
          if (c == 16'd44 || c == 16'd125) begin
            r0 = mk(blt_pkg::EV_END, 16'd0, vtype, blt_pkg::ER_NONE, depth_r);
            k = 2'd1;
            if (c == 16'd44) mode_nxt = M_VALUE; else cl = 1'b1;
          end else begin
            fd = 1'b1;
            r0 = mk(blt_pkg::EV_CHAR, c, blt_pkg::VT_NONE, blt_pkg::ER_NONE, depth_r);
            k = 2'd1;
          end
        end
        default: ;
      endcase
      if (cl) begin
        blt_pkg::out_item_t t;
        if (depth_r == 8'd0) begin
          mode_nxt = M_FAILED; serr_nxt = blt_pkg::ER_EXTRA;
          t = mk(blt_pkg::EV_ERR, 16'd0, blt_pkg::VT_NONE, blt_pkg::ER_EXTRA, depth_r);
        end else begin
          depth_nxt = depth_r - 8'd1; nonempty_nxt = 1'b1; mode_nxt = M_DELIM;
          t = mk(blt_pkg::EV_CLOSE, 16'd0, blt_pkg::VT_NONE, blt_pkg::ER_NONE, depth_nxt);
        end
        if (k == 2'd0) r0 = t; else r1 = t;
        k = k + 2'd1;
      end
    end

    // recognizers: restart at a new value, then take the character
    if (st) begin
      len_nxt = 16'd0; num_nxt = N_START; guid_nxt = 1'b1; lph_nxt = L_START;
      lhex_nxt = 6'd0; b64_nxt = 1'b1; b64p_nxt = 1'b1; datp_nxt = 1'b1;
    end
    if (fd) begin
      logic [15:0] p;
      p = st ? 16'd0 : len_r;
      unique case (st ? N_START : num_r)
        N_START:  num_nxt = (c == 16'd45) ? N_MINUS : (d ? N_INT : N_DEAD);
        N_MINUS:  num_nxt = d ? N_INT : N_DEAD;
        N_INT:    num_nxt = d ? N_INT : (c == 16'd46 ? N_FRAC : (e ? N_E : N_DEAD));
        N_FRAC:   num_nxt = d ? N_FRAC : (e ? N_E : N_DEAD);
        N_E:      num_nxt = (c == 16'd45) ? N_EMINUS : (d ? N_EXP : N_DEAD);
        N_EMINUS: num_nxt = d ? N_EXP : N_DEAD;
        N_EXP:    num_nxt = d ? N_EXP : N_DEAD;
        default:  num_nxt = N_DEAD;
      endcase
      if (p >= 16'd36) guid_nxt = 1'b0;
      else if (p == 16'd8 || p == 16'd13 || p == 16'd18 || p == 16'd23) begin
        if (c != 16'd45) guid_nxt = 1'b0;
      end else if (!blt_pkg::is_hex(c)) guid_nxt = 1'b0;
      unique case (st ? L_START : lph_r)
        L_START:  lph_nxt = d ? L_DIGITS : L_DEAD;
        L_DIGITS: lph_nxt = d ? L_DIGITS : (c == 16'd58 ? L_HEX : L_DEAD);
        L_HEX: begin
          if (blt_pkg::is_hex(c) && lhex_r < 6'd32) lhex_nxt = lhex_r + 6'd1;
          else lph_nxt = L_DEAD;
        end
        default:  lph_nxt = L_DEAD;
      endcase
      if (!blt_pkg::is_b64(c)) b64_nxt = 1'b0;
      if (p < 16'd8) begin
        if (c != blt_pkg::pfx_b64(p[2:0])) b64p_nxt = 1'b0;
      end else if (!blt_pkg::is_b64(c)) b64p_nxt = 1'b0;
      if (p < 16'd6) begin
        if (c != blt_pkg::pfx_data(p[2:0])) datp_nxt = 1'b0;
      end else if (!blt_pkg::is_b64(c)) datp_nxt = 1'b0;
      if (p != 16'hFFFF) len_nxt = p + 16'd1;
    end
    if (k == 2'd1) r0.last = 1'b1;
    if (k == 2'd2) r1.last = 1'b1;
  end

  // output slots
  always_comb begin
    logic [1:0] rem;
    o0_nxt = o0_r; o1_nxt = o1_r;
    rem = ocnt_r;
    if (out_valid && out_ready) begin
      o0_nxt = o1_r;
      rem = ocnt_r - 2'd1;
    end
    ocnt_nxt = rem;
    if (take && k != 2'd0) begin
      // rem is zero here by q_ready
      o0_nxt = r0; o1_nxt = r1; ocnt_nxt = k;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_VALUE; depth_r <= 8'd0; nonempty_r <= 1'b0; len_r <= 16'd0;
      num_r <= N_START; guid_r <= 1'b1; lph_r <= L_START; lhex_r <= 6'd0;
      b64_r <= 1'b1; b64p_r <= 1'b1; datp_r <= 1'b1; serr_r <= 3'd0;
      ocnt_r <= 2'd0;
    end else begin
      if (take) begin
        mode_r <= mode_nxt; depth_r <= depth_nxt; nonempty_r <= nonempty_nxt;
        len_r <= len_nxt; num_r <= num_nxt; guid_r <= guid_nxt; lph_r <= lph_nxt;
        lhex_r <= lhex_nxt; b64_r <= b64_nxt; b64p_r <= b64p_nxt; datp_r <= datp_nxt;
        serr_r <= serr_nxt;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o0_r <= o0_nxt;
    o1_r <= o1_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) ocnt_r != 2'd3)
    else $error("output slot count out of range");
  a_two_last: assert property (@(posedge clk) disable iff (!rst_n)
      ocnt_r == 2'd2 |-> !o0_r.last && o1_r.last)
    else $error("two-result group has misplaced last flag");
  a_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
      take && k != 2'd0 |-> ocnt_r == 2'd0 || out_ready)
    else $error("results loaded over pending results");
  a_failed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
      take && mode_r == M_FAILED && !q_data.fin |=> ocnt_r == 2'd0 || $stable(o0_r))
    else $error("characters in failed mode produced a result");
endmodule
`default_nettype wire

// File: rtl/core/brace_list_tokenizer.sv
// brace_list_tokenizer: top level; input queue stage and parser back end.
// Depends on blt_pkg, blt_front, blt_back.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel | dir | ports                       | payload
//  --------+-----+-----------------------------+--------------------------------
//  input   | in  | in_valid, in_ready, in_data | blt_pkg::in_item_t (opcode, char)
//  result  | out | out_valid, out_ready,       | blt_pkg::out_item_t (event, char,
//          |     | out_data                    |  type, error, depth, last)
//
//  One character per cycle in steady state; an item causing two results (close
//  after value end, empty before close, error after string end, end-of-text
//  checks) holds the parser while the second result is shown.
//  Items pass through the two-entry input queue; results leave through the
//  output register. Synchronous active-low reset returns the parser to
//  "awaiting value", depth 0. Either side may stall freely; the queue
//  absorbs input while results wait.
module brace_list_tokenizer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire blt_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output blt_pkg::out_item_t     out_data
);
  logic          q_valid, q_ready;
  blt_pkg::cmd_t q_data;

  // front: accept and classify end-of-text, buffer two transfers
  blt_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  // back: parser state, recognizers and result slots
  blt_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule
`default_nettype wire

// File: tb/brace_list_tokenizer_test.sv
// brace_list_tokenizer_test: self-checking bench for the brace list tokenizer.
// Drives characters and end-of-text items, predicts events in-bench, compares them.
// Depends on blt_pkg and brace_list_tokenizer.
`timescale 1ns / 1ps
module brace_list_tokenizer_test;
  import blt_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  // Parser modes of the predictor.
  typedef enum logic [2:0] {
    PM_VALUE, PM_DELIM, PM_STRING, PM_QUOTE, PM_BARE, PM_FAILED
  } pmode_t;
  // Number recognizer states.
  typedef enum logic [2:0] {
    NS_START, NS_MINUS, NS_INT, NS_FRAC, NS_E, NS_EMINUS, NS_EXP, NS_DEAD
  } nstate_t;
  // Link recognizer phases.
  typedef enum logic [1:0] {LK_START, LK_DIGITS, LK_HEX, LK_DEAD} lphase_t;

  localparam logic [15:0] CH_QUOTE = 16'd34;
  localparam logic [15:0] CH_OPEN  = 16'd123;
  localparam logic [15:0] CH_CLOSE = 16'd125;
  localparam logic [15:0] CH_COMMA = 16'd44;
  localparam logic [15:0] CH_MINUS = 16'd45;
  localparam logic [15:0] CH_DOT   = 16'd46;
  localparam logic [15:0] CH_COLON = 16'd58;
  localparam logic       OP_CHAR  = 1'b0;
  localparam logic       OP_EOT   = 1'b1;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_item_t in_data;
  out_item_t out_data;

  brace_list_tokenizer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the tokenizer's registers.
  // ---------------------------------------------------------------------------
  pmode_t      mode;
  logic [7:0]  depth;
  logic        nonempty;
  int unsigned vlen;
  nstate_t     nst;
  logic        guid_good;
  lphase_t     lph;
  int unsigned lhex;
  logic        b64_good, b64pfx_good, datapfx_good;
  logic [2:0]  held_err;

  out_item_t pending_events[$];  // events still owed by the tokenizer
  out_item_t step_events[$];     // events of the item being predicted

  int errors, matched, accepted_in;
  int ev_hist[8];
  int vt_hist[16];
  int er_hist[8];

  // Character classes, written out here rather than borrowed from the package.
  function automatic logic c_dig(logic [15:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic c_hex(logic [15:0] c);
    return c_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction
  function automatic logic c_b64(logic [15:0] c);
    return c_dig(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           c == "+" || c == "=" || c == "/" || c == 16'd13 || c == 16'd10;
  endfunction
  function automatic logic c_ws(logic [15:0] c);
    return c == 16'd32 || c == 16'd9 || c == 16'd13 || c == 16'd10;
  endfunction

  task automatic clear_value();
    vlen = 0; nst = NS_START; guid_good = 1'b1; lph = LK_START; lhex = 0;
    b64_good = 1'b1; b64pfx_good = 1'b1; datapfx_good = 1'b1;
  endtask

  task automatic clear_all();
    mode = PM_VALUE; depth = 8'd0; nonempty = 1'b0; held_err = ER_NONE;
    clear_value();
  endtask

  task automatic push_ev(logic [2:0] ev, logic [15:0] ch, logic [3:0] vt, logic [2:0] er);
    out_item_t r;
    r.event_res = ev; r.char_out = ch; r.value_type = vt; r.error_code = er;
    r.nest_depth = depth; r.last = 1'b0;
    step_events.push_back(r);
  endtask

  task automatic fail_with(logic [2:0] er);
    mode = PM_FAILED; held_err = er;
    push_ev(EV_ERR, 16'd0, VT_NONE, er);
  endtask

  task automatic close_list();
    if (depth == 8'd0) begin
      fail_with(ER_EXTRA);
    end else begin
      depth--; nonempty = 1'b1; mode = PM_DELIM;
      push_ev(EV_CLOSE, 16'd0, VT_NONE, ER_NONE);
    end
  endtask

  // Advance all value recognizers by one character.
  task automatic recognize(logic [15:0] c);
    logic [15:0] b64p[8];
    logic [15:0] datp[6];
    logic d, e;
    b64p = '{"#", "b", "a", "s", "e", "6", "4", ":"};
    datp = '{"#", "d", "a", "t", "a", ":"};
    d = c_dig(c);
    e = (c == "e" || c == "E");
    case (nst)
      NS_START:  nst = (c == CH_MINUS) ? NS_MINUS : (d ? NS_INT : NS_DEAD);
      NS_MINUS:  nst = d ? NS_INT : NS_DEAD;
      NS_INT:    nst = d ? NS_INT : (c == CH_DOT ? NS_FRAC : (e ? NS_E : NS_DEAD));
      NS_FRAC:   nst = d ? NS_FRAC : (e ? NS_E : NS_DEAD);
      NS_E:      nst = (c == CH_MINUS) ? NS_EMINUS : (d ? NS_EXP : NS_DEAD);
      NS_EMINUS: nst = d ? NS_EXP : NS_DEAD;
      NS_EXP:    nst = d ? NS_EXP : NS_DEAD;
      default:   nst = NS_DEAD;
    endcase
    if (vlen >= 36) guid_good = 1'b0;
    else if (vlen == 8 || vlen == 13 || vlen == 18 || vlen == 23) begin
      if (c != CH_MINUS) guid_good = 1'b0;
    end else if (!c_hex(c)) guid_good = 1'b0;
    case (lph)
      LK_START:  lph = d ? LK_DIGITS : LK_DEAD;
      LK_DIGITS: lph = d ? LK_DIGITS : (c == CH_COLON ? LK_HEX : LK_DEAD);
      LK_HEX: begin
        if (c_hex(c) && lhex < 32) lhex++;
        else lph = LK_DEAD;
      end
      default:   lph = LK_DEAD;
    endcase
    if (!c_b64(c)) b64_good = 1'b0;
    if (vlen < 8) begin
      if (c != b64p[vlen]) b64pfx_good = 1'b0;
    end else if (!c_b64(c)) b64pfx_good = 1'b0;
    if (vlen < 6) begin
      if (c != datp[vlen]) datapfx_good = 1'b0;
    end else if (!c_b64(c)) datapfx_good = 1'b0;
    if (vlen < 65535) vlen++;
  endtask

  function automatic logic [3:0] value_kind();
    if (vlen == 0) return VT_NONE;
    if (nst == NS_INT) return VT_INT;
    if (nst == NS_FRAC || nst == NS_EXP) return VT_EXP;
    if (guid_good && vlen == 36) return VT_GUID;
    if (b64pfx_good && vlen >= 8) return VT_B64;
    if (lph == LK_HEX && lhex == 32) return VT_LINK;
    if (b64_good) return VT_BARE64;
    if (datapfx_good && vlen >= 6) return VT_DATA;
    return VT_UNKNOWN;
  endfunction

  // Predict the events of one accepted item and queue them.
  task automatic tokenize(in_item_t it);
    logic [15:0] c;
    logic bad;
    c = it.char_code;
    bad = 1'b0;
    step_events.delete();
    if (it.opcode == OP_EOT || c == 16'd0) begin
      case (mode)
        PM_BARE:   push_ev(EV_END, 16'd0, value_kind(), ER_NONE);
        PM_QUOTE:  push_ev(EV_END, 16'd0, VT_STRING, ER_NONE);
        PM_DELIM:  ;
        PM_FAILED: begin push_ev(EV_ERR, 16'd0, VT_NONE, held_err); bad = 1'b1; end
        default:   begin push_ev(EV_ERR, 16'd0, VT_NONE, ER_UNFIN); bad = 1'b1; end
      endcase
      if (!bad) begin
        if (depth != 8'd0) push_ev(EV_ERR, 16'd0, VT_NONE, ER_MISSING);
        else push_ev(EV_DONE, 16'd0, VT_NONE, ER_NONE);
      end
      clear_all();
    end else begin
      case (mode)
        PM_VALUE: begin
          if (c_ws(c)) begin
          end else if (c == CH_QUOTE) begin
            mode = PM_STRING;
          end else if (c == CH_OPEN) begin
            if (depth >= MAX_DEPTH) fail_with(ER_DEEP);
            else begin
              depth++; nonempty = 1'b0;
              push_ev(EV_OPEN, 16'd0, VT_NONE, ER_NONE);
            end
          end else if (c == CH_CLOSE) begin
            if (nonempty) push_ev(EV_EMPTY, 16'd0, VT_NONE, ER_NONE);
            close_list();
          end else if (c == CH_COMMA) begin
            nonempty = 1'b1;
            push_ev(EV_EMPTY, 16'd0, VT_NONE, ER_NONE);
          end else begin
            clear_value();
            recognize(c);
            nonempty = 1'b1; mode = PM_BARE;
            push_ev(EV_CHAR, c, VT_NONE, ER_NONE);
          end
        end
        PM_DELIM: begin
          if (c_ws(c)) begin
          end else if (c == CH_COMMA) mode = PM_VALUE;
          else if (c == CH_CLOSE) close_list();
          else fail_with(ER_DELIM);
        end
        PM_STRING: begin
          if (c == CH_QUOTE) mode = PM_QUOTE;
          else push_ev(EV_CHAR, c, VT_NONE, ER_NONE);
        end
        PM_QUOTE: begin
          if (c == CH_QUOTE) begin
            mode = PM_STRING;
            push_ev(EV_CHAR, c, VT_NONE, ER_NONE);
          end else begin
            nonempty = 1'b1;
            push_ev(EV_END, 16'd0, VT_STRING, ER_NONE);
            if (c_ws(c)) mode = PM_DELIM;
            else if (c == CH_COMMA) mode = PM_VALUE;
            else if (c == CH_CLOSE) close_list();
            else fail_with(ER_DELIM);
          end
        end
        PM_BARE: begin
          if (c == CH_COMMA) begin
            mode = PM_VALUE;
            push_ev(EV_END, 16'd0, value_kind(), ER_NONE);
          end else if (c == CH_CLOSE) begin
            push_ev(EV_END, 16'd0, value_kind(), ER_NONE);
            close_list();
          end else begin
            recognize(c);
            push_ev(EV_CHAR, c, VT_NONE, ER_NONE);
          end
        end
        default: ;  // failed: silent until end of text
      endcase
    end
    if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
    foreach (step_events[i]) pending_events.push_back(step_events[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus storage: items are prepared into a queue, then streamed out.
  // ---------------------------------------------------------------------------
  in_item_t feed_q[$];
  // Directed rows, some with a hand-typed first event; has_exp=0 rows rely on the predictor alone.
  typedef struct {
    in_item_t  item;
    logic      has_exp;
    logic [2:0] ev;
    logic [2:0] er;
  } drow_t;
  drow_t dir_rows[$];
  out_item_t typed_first[int];  // keyed by input index

  function automatic in_item_t mk(logic op, logic [15:0] c);
    in_item_t r;
    r.opcode = op; r.char_code = c;
    return r;
  endfunction

  task automatic add_row(logic op, logic [15:0] c, logic h, logic [2:0] ev, logic [2:0] er);
    drow_t r;
    r.item = mk(op, c); r.has_exp = h; r.ev = ev; r.er = er;
    dir_rows.push_back(r);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) feed_q.push_back(mk(OP_CHAR, 16'(s[i])));
  endtask

  task automatic add_eot();
    feed_q.push_back(mk(OP_EOT, 16'($urandom)));
  endtask

  function automatic string hexs(int n);
    string s, h;
    h = "0123456789abcdefABCDEF";
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(h[$urandom_range(0, 21)])};
    return s;
  endfunction

  function automatic string rand_value();
    string s;
    int k;
    k = $urandom_range(0, 11);
    case (k)
      0: s = $sformatf("%0d", $urandom_range(0, 99999));
      1: s = $sformatf("-%0d.%0de-%0d", $urandom_range(0, 99), $urandom_range(0, 99),
                       $urandom_range(0, 9));
      2: s = {hexs(8), "-", hexs(4), "-", hexs(4), "-", hexs(4), "-", hexs(12)};
      3: s = {"#base64:", "QUJD+/=="};
      4: s = {$sformatf("%0d", $urandom_range(0, 999)), ":", hexs(32)};
      5: s = "SGVsbG8gd29ybGQ";
      6: s = {"#data:", "AAAA"};
      7: s = "\"ab\"\"c\"";
      8: s = "\"\"";
      9: s = "x y.z";
      10: s = {"1e", $sformatf("%0d", $urandom_range(0, 9))};
      default: s = "";
    endcase
    return s;
  endfunction

  // Well-formed nested list with random content.
  function automatic string rand_list(int lvl);
    string s;
    int n;
    n = $urandom_range(0, 4);
    s = "{";
    for (int i = 0; i < n; i++) begin
      if (i > 0) s = {s, ($urandom_range(0, 3) == 0) ? ", " : ","};
      if (lvl < 3 && $urandom_range(0, 4) == 0) s = {s, rand_list(lvl + 1)};
      else s = {s, rand_value()};
    end
    return {s, "}"};
  endfunction

  task automatic add_random_text();
    int k;
    string s;
    k = $urandom_range(0, 19);
    if (k < 14) begin
      s = rand_list(0);
      // Occasionally damage a well-formed list.
      if (k == 12 && s.len() > 2) s = s.substr(0, s.len() - 2);
      if (k == 13) s = {s, "}x"};
      add_text(s);
    end else if (k < 17) begin
      // Noise: arbitrary 16-bit code units, never zero here.
      repeat ($urandom_range(1, 12))
        feed_q.push_back(mk(OP_CHAR, 16'($urandom_range(1, 65535))));
    end else if (k == 17) begin
      add_text("{{");
      feed_q.push_back(mk(OP_CHAR, 16'h8000 | 16'($urandom)));
      feed_q.push_back(mk(OP_CHAR, 16'h7fff & 16'($urandom_range(1, 32767))));
    end else begin
      add_text(rand_value());
    end
    if ($urandom_range(0, 9) == 0) feed_q.push_back(mk(OP_CHAR, 16'd0));
    else add_eot();
  endtask

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_all();
    int gap;
    for (int i = 0; i < feed_q.size(); i++) begin
      in_valid <= 1'b1;
      in_data  <= feed_q[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      // First segment runs without gaps so back-to-back behavior is covered.
      gap = (i < 300) ? 0 : pick_gap();
      if (gap > 0 || i + 1 == feed_q.size()) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Prediction at every input transfer.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      tokenize(in_data);
      accepted_in <= accepted_in + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls plus one long hold-off to fill the block.
  // ---------------------------------------------------------------------------
  logic long_hold;
  initial begin
    long_hold = 1'b0;
    wait (accepted_in > 100);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (200) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (long_hold) out_ready <= 1'b0;
    else out_ready <= (accepted_in < 400 && accepted_in > 250) ? 1'b1
                                                              : ($urandom_range(0, 9) < 7);
  end

  // Result check: field by field against the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_ev;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: event %0d err %0d",
                   out_data.event_res, out_data.error_code);
      end else begin
        exp_ev = pending_events.pop_front();
        if (out_data !== exp_ev) begin
          errors++;
          if (errors <= 10)
            $display({"result %0d: expected ev=%0d ch=%h vt=%0d er=%0d d=%0d l=%0d, ",
                      "got ev=%0d ch=%h vt=%0d er=%0d d=%0d l=%0d"},
                     matched + errors, exp_ev.event_res, exp_ev.char_out, exp_ev.value_type,
                     exp_ev.error_code, exp_ev.nest_depth, exp_ev.last,
                     out_data.event_res, out_data.char_out, out_data.value_type,
                     out_data.error_code, out_data.nest_depth, out_data.last);
        end else begin
          matched++;
        end
        ev_hist[out_data.event_res]++;
        vt_hist[out_data.value_type]++;
        er_hist[out_data.error_code]++;
      end
    end
  end

  // Watchdog: cycles without any transfer.
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("brace_list_tokenizer: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    errors = 0; matched = 0; accepted_in = 0;
    clear_all();

    // Directed table. Rows with a typed first event are cross-checked
    // against the predictor when it runs on them.
    add_row(OP_EOT,  16'hffff, 1, EV_ERR, ER_UNFIN);     // empty text
    add_row(OP_CHAR, CH_CLOSE, 1, EV_ERR, ER_EXTRA);     // stray close
    add_row(OP_CHAR, 16'd0,    1, EV_ERR, ER_EXTRA);     // end repeats saved code
    add_row(OP_CHAR, CH_OPEN,  1, EV_OPEN, ER_NONE);
    add_row(OP_CHAR, 16'd32,   0, 0, 0);                  // skipped space
    add_row(OP_CHAR, CH_COMMA, 1, EV_EMPTY, ER_NONE);
    add_row(OP_CHAR, CH_CLOSE, 1, EV_EMPTY, ER_NONE);    // empty before close
    add_row(OP_CHAR, 16'hffff, 1, EV_ERR, ER_DELIM);     // bad delimiter, top char
    add_row(OP_EOT,  16'd0,    1, EV_ERR, ER_DELIM);
    add_row(OP_CHAR, CH_OPEN,  1, EV_OPEN, ER_NONE);
    add_row(OP_CHAR, CH_QUOTE, 0, 0, 0);
    add_row(OP_CHAR, 16'd1,    1, EV_CHAR, ER_NONE);
    add_row(OP_CHAR, CH_QUOTE, 0, 0, 0);
    add_row(OP_CHAR, CH_QUOTE, 1, EV_CHAR, ER_NONE);     // doubled quote
    add_row(OP_CHAR, CH_QUOTE, 0, 0, 0);
    add_row(OP_CHAR, 16'h8000, 1, EV_END, ER_NONE);      // string end, then error
    add_row(OP_EOT,  16'd0,    1, EV_ERR, ER_DELIM);
    add_row(OP_CHAR, 16'd57,   1, EV_CHAR, ER_NONE);     // bare number at top level
    add_row(OP_EOT,  16'd0,    1, EV_END, ER_NONE);
    add_row(OP_CHAR, CH_OPEN,  1, EV_OPEN, ER_NONE);
    add_row(OP_EOT,  16'd0,    1, EV_ERR, ER_UNFIN);     // end while awaiting a value
    add_row(OP_CHAR, CH_QUOTE, 0, 0, 0);
    add_row(OP_EOT,  16'd0,    1, EV_ERR, ER_UNFIN);     // unfinished string
    foreach (dir_rows[i]) begin
      feed_q.push_back(dir_rows[i].item);
      if (dir_rows[i].has_exp) begin
        typed_first[i] = '0;
        typed_first[i].event_res = dir_rows[i].ev;
        typed_first[i].error_code = dir_rows[i].er;
      end
    end
    // Nesting to the limit and one beyond.
    repeat (MAX_DEPTH + 1) feed_q.push_back(mk(OP_CHAR, CH_OPEN));
    add_eot();
    // Classified values.
    add_text("{12,-3.5e-7,01234567-89ab-cdef-0123-456789ABCDEF,#base64:QUJD,");
    add_text("5:0123456789abcdef0123456789ABCDEF,QUJD,#data:x,a b,\" \"}");
    add_eot();
    while (feed_q.size() < 1150) add_random_text();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_all();

    // Drain; then allow for the block's latency.
    while (pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    // Typed expectations vs. what the block returned is covered by the
    // predictor; check the table itself agrees with the predictor too.
    clear_all();
    for (int i = 0; i < dir_rows.size(); i++) begin
      pending_events.delete();
      tokenize(dir_rows[i].item);
      if (typed_first.exists(i)) begin
        if (pending_events.size() == 0 ||
            pending_events[0].event_res != typed_first[i].event_res ||
            pending_events[0].error_code != typed_first[i].error_code) begin
          errors++;
          if (errors <= 10) $display("directed row %0d: typed expectation differs", i);
        end
      end
    end
    pending_events.delete();

    $display("covered %0d items, %0d results: open %0d close %0d empty %0d char %0d end %0d",
             accepted_in, matched, ev_hist[EV_OPEN], ev_hist[EV_CLOSE], ev_hist[EV_EMPTY],
             ev_hist[EV_CHAR], ev_hist[EV_END]);
    $display("done %0d, errors %0d (deep %0d), int %0d guid %0d link %0d data %0d",
             ev_hist[EV_DONE], ev_hist[EV_ERR], er_hist[ER_DEEP], vt_hist[VT_INT],
             vt_hist[VT_GUID], vt_hist[VT_LINK], vt_hist[VT_DATA]);
    if (errors == 0) begin
      $display("brace_list_tokenizer: match");
    end else begin
      $display("brace_list_tokenizer: mismatch");
    end
    $finish;
  end

endmodule

// File: brace_list_tokenizer.f
rtl/core/blt_pkg.sv
rtl/core/blt_front.sv
rtl/core/blt_back.sv
rtl/core/brace_list_tokenizer.sv
tb/brace_list_tokenizer_test.sv
